[hw/rtl/ffdl_pkg.sv]
// Shared constants, types and helper functions for the fractional feedback delay line.
package ffdl_pkg;

    // Buffer geometry
    localparam int BUFFER_FRAMES = 4096;
    localparam int CHANNELS      = 2;
    localparam int LANES         = 2;
    localparam int ADDR_W        = (BUFFER_FRAMES > 1) ? $clog2(BUFFER_FRAMES) : 1;

    // Sample, gain and delay formats
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int DELAY_W   = 20;
    localparam int FRAC_BITS = 8;
    localparam int WHOLE_W   = DELAY_W - FRAC_BITS;
    localparam int IDX_W     = ((ADDR_W > WHOLE_W) ? ADDR_W : WHOLE_W) + 1;
    localparam logic [31:0] DELAY_LIMIT = 32'((BUFFER_FRAMES - 1) * (1 << FRAC_BITS));

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_FRAMES    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_GAIN      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRY_GAIN        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WET_GAIN        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_ENABLE = 3'd5;

    // Register reset values
    localparam logic [DELAY_W-1:0]       DELAY_FRAMES_RST  = 20'd1048320;
    localparam logic signed [GAIN_W-1:0] DELAY_GAIN_RST    = 16'sd16384;
    localparam logic signed [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] DRY_GAIN_RST      = 16'sd16384;
    localparam logic signed [GAIN_W-1:0] WET_GAIN_RST      = 16'sd16384;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic read_step;
        logic interp_step;
        logic scale_step;
        logic commit;
    } ffdl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } ffdl_status_t;

    // Saturate a 21-bit signed value to a Q1.15 sample
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [20:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 21'sd32767) begin
            r = 16'sd32767;
        end else if (v < -21'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/ffdl_ram.sv]
// Generic RAM with one write port and two registered read ports.
module ffdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[hw/rtl/ffdl_ctrl.sv]
// Frame sequencer: steps one frame through read, interpolate, scale and mix.
module ffdl_ctrl
    import ffdl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ffdl_status_t status,
    output ffdl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_INTERP = 5'b00100,
        ST_SCALE  = 5'b01000,
        ST_MIX    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_MIX;
            ST_MIX: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode commands
    assign s_ready         = (state_reg == ST_IDLE);
    assign cmd.accept      = (state_reg == ST_IDLE) && s_valid;
    assign cmd.read_step   = (state_reg == ST_READ);
    assign cmd.interp_step = (state_reg == ST_INTERP);
    assign cmd.scale_step  = (state_reg == ST_SCALE);
    assign cmd.commit      = (state_reg == ST_MIX) && status.out_free;

endmodule

[hw/rtl/ffdl_datapath.sv]
// Datapath: settings registers, write position, sample stores and per-channel arithmetic.
module ffdl_datapath
    import ffdl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic signed [SAMPLE_W-1:0] s_left_in,
    input  logic signed [SAMPLE_W-1:0] s_right_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_left_out,
    output logic signed [SAMPLE_W-1:0] m_right_out,
    input  ffdl_cmd_t                  cmd,
    output ffdl_status_t               status
);

    logic [DELAY_W-1:0]       delay_frames_reg;
    logic signed [GAIN_W-1:0] delay_gain_reg;
    logic signed [GAIN_W-1:0] feedback_gain_reg;
    logic signed [GAIN_W-1:0] dry_gain_reg;
    logic signed [GAIN_W-1:0] wet_gain_reg;
    logic                     feedback_enable_reg;

    logic [ADDR_W-1:0]    wp_reg;
    logic                 full_reg;
    logic                 m_valid_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic                 v1_reg, v2_reg, byp1_reg, byp2_reg;

    logic [DELAY_W-1:0] delay_clamped;
    logic [WHOLE_W-1:0] whole;
    logic [IDX_W-1:0]   wp_ext, whole_ext, r1_ext;
    logic [ADDR_W-1:0]  r1, r2;

    logic signed [SAMPLE_W-1:0] x_in  [LANES];
    logic signed [SAMPLE_W-1:0] y_out [LANES];

    assign x_in[0]     = s_left_in;
    assign x_in[1]     = s_right_in;
    assign m_left_out  = y_out[0];
    assign m_right_out = y_out[1];

    // Settings register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_frames_reg    <= DELAY_FRAMES_RST;
            delay_gain_reg      <= DELAY_GAIN_RST;
            feedback_gain_reg   <= FEEDBACK_GAIN_RST;
            dry_gain_reg        <= DRY_GAIN_RST;
            wet_gain_reg        <= WET_GAIN_RST;
            feedback_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DELAY_FRAMES:    delay_frames_reg    <= cfg_wdata[DELAY_W-1:0];
                CFG_DELAY_GAIN:      delay_gain_reg      <= cfg_wdata[GAIN_W-1:0];
                CFG_FEEDBACK_GAIN:   feedback_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_DRY_GAIN:        dry_gain_reg        <= cfg_wdata[GAIN_W-1:0];
                CFG_WET_GAIN:        wet_gain_reg        <= cfg_wdata[GAIN_W-1:0];
                CFG_FEEDBACK_ENABLE: feedback_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp the delay and form both read addresses behind the write position
    always_comb begin
        delay_clamped = (32'(delay_frames_reg) > DELAY_LIMIT) ? DELAY_LIMIT[DELAY_W-1:0]
                                                              : delay_frames_reg;
        whole     = delay_clamped[DELAY_W-1:FRAC_BITS];
        wp_ext    = IDX_W'(wp_reg);
        whole_ext = IDX_W'(whole);
        r1_ext    = (wp_ext >= whole_ext) ? (wp_ext - whole_ext)
                                          : (wp_ext + IDX_W'(BUFFER_FRAMES) - whole_ext);
        r1 = r1_ext[ADDR_W-1:0];
        r2 = (r1 == '0) ? ADDR_W'(BUFFER_FRAMES - 1) : (r1 - 1'b1);
    end

    // Capture fraction, fill and bypass flags with the transaction
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            frac_reg <= delay_clamped[FRAC_BITS-1:0];
            byp1_reg <= (r1 == wp_reg);
            byp2_reg <= (r2 == wp_reg);
            v1_reg   <= full_reg || (r1 <= wp_reg);
            v2_reg   <= full_reg || (r2 <= wp_reg);
        end
    end

    // Advance the write position; mark the store full after the first wrap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end else if (cmd.commit) begin
            if (wp_reg == ADDR_W'(BUFFER_FRAMES - 1)) begin
                wp_reg   <= '0;
                full_reg <= 1'b1;
            end else begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    // Output register: hold until the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    // One lane per channel, each with its own sample store
    for (genvar c = 0; c < LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_used
            logic signed [SAMPLE_W-1:0] x_reg;
            logic signed [SAMPLE_W-1:0] s1_reg;
            logic signed [25:0]         p1_reg;
            logic signed [32:0]         p2_reg;
            logic signed [33:0]         fbp_reg;
            logic signed [33:0]         mixw_reg;
            logic signed [31:0]         mixd_reg;
            logic signed [SAMPLE_W-1:0] out_reg;

            logic [SAMPLE_W-1:0]        rd_a, rd_b;
            logic signed [SAMPLE_W-1:0] s1, s2;
            logic signed [16:0]         diff;
            logic signed [17:0]         interp_sum;
            logic signed [16:0]         interp;
            logic signed [17:0]         delayed;
            logic signed [34:0]         mix_sum;
            logic signed [20:0]         fb_sum;
            logic signed [SAMPLE_W-1:0] stored;

            ffdl_ram #(
                .WIDTH (SAMPLE_W),
                .DEPTH (BUFFER_FRAMES)
            ) u_store (
                .clk       (aclk),
                .wr_en     (cmd.commit),
                .wr_addr   (wp_reg),
                .wr_data   (stored),
                .rd_en     (cmd.accept),
                .rd_addr_a (r1),
                .rd_addr_b (r2),
                .rd_data_a (rd_a),
                .rd_data_b (rd_b)
            );

            // Pick stored, just-written or never-written samples
            always_comb begin
                s1 = byp1_reg ? x_reg : (v1_reg ? $signed(rd_a) : '0);
                s2 = byp2_reg ? x_reg : (v2_reg ? $signed(rd_b) : '0);
                diff = {s2[SAMPLE_W-1], s2} - {s1[SAMPLE_W-1], s1};
                interp_sum = {{2{s1_reg[SAMPLE_W-1]}}, s1_reg} + p1_reg[25:FRAC_BITS];
                interp     = interp_sum[16:0];
                delayed    = p2_reg[31:14];
                mix_sum    = {{3{mixd_reg[31]}}, mixd_reg} + {mixw_reg[33], mixw_reg};
                fb_sum     = {{5{x_reg[SAMPLE_W-1]}}, x_reg} + {fbp_reg[33], fbp_reg[33:14]};
                stored     = feedback_enable_reg ? sat16(fb_sum) : x_reg;
            end

            // Arithmetic stages, one multiply rank per step
            always_ff @(posedge aclk) begin
                if (cmd.accept) begin
                    x_reg <= x_in[c];
                end
                if (cmd.read_step) begin
                    s1_reg <= s1;
                    p1_reg <= $signed({1'b0, frac_reg}) * diff;
                end
                if (cmd.interp_step) begin
                    p2_reg <= delay_gain_reg * interp;
                end
                if (cmd.scale_step) begin
                    fbp_reg  <= delayed * feedback_gain_reg;
                    mixw_reg <= delayed * wet_gain_reg;
                    mixd_reg <= x_reg * dry_gain_reg;
                end
                if (cmd.commit) begin
                    out_reg <= sat16(mix_sum[34:14]);
                end
            end

            assign y_out[c] = out_reg;
        end else begin : g_unused
            assign y_out[c] = '0;
        end
    end

endmodule

[hw/rtl/fractional_feedback_delay_line.sv]
// Top level of the stereo fractional feedback delay line.
//
// Input channel s_*: one stereo frame (s_left_in, s_right_in, Q1.15) per
// transaction. Output channel m_*: the mixed frame (m_left_out, m_right_out),
// one transaction out for each transaction in, in order.
// Settings port cfg_*: a write takes effect at the clock edge with cfg_we high;
// write only while no frame is in flight.
// A frame steps through accept, read/difference, interpolate, scale and mix:
// accept issues both delayed-frame reads to the per-channel sample store, the
// read/difference, interpolate and scale steps each pass one rank of multipliers,
// and mix loads the output register; s_ready returns in the same cycle as m_valid rises.
// The store needs no clearing pass: a fill flag marks entries not yet written
// since reset and those read as zero, so frames are taken straight after reset.
// Reset (aresetn low, synchronous) returns the settings to their defaults,
// the write position to zero and drops any pending result.
// When the receiver stalls, the finished frame holds in the output register
// while the next frame is accepted and worked on; it then waits in the mix
// step until the output register is free.
module fractional_feedback_delay_line
    import ffdl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_left_in,
    input  logic signed [SAMPLE_W-1:0] s_right_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_left_out,
    output logic signed [SAMPLE_W-1:0] m_right_out
);

    ffdl_cmd_t    cmd;
    ffdl_status_t status;

    ffdl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ffdl_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

[sim/fractional_feedback_delay_line_test.sv]
// Self-checking testbench for the stereo fractional feedback delay line.
import ffdl_pkg::*;

typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
} stereo_frame_t;

// Predicts each mixed frame and checks the frames that come out of the block
class delay_line_scoreboard;
    logic signed [SAMPLE_W-1:0] frames [BUFFER_FRAMES][CHANNELS];
    int unsigned                write_pos;
    logic [DELAY_W-1:0]         delay_frames;
    logic signed [GAIN_W-1:0]   delay_gain;
    logic signed [GAIN_W-1:0]   feedback_gain;
    logic signed [GAIN_W-1:0]   dry_gain;
    logic signed [GAIN_W-1:0]   wet_gain;
    bit                         feedback_on;
    stereo_frame_t              pending_frames [$];
    int                         failures;
    int                         frames_checked;

    function new();
        for (int f = 0; f < BUFFER_FRAMES; f++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                frames[f][c] = '0;
            end
        end
        write_pos      = 0;
        delay_frames   = DELAY_FRAMES_RST;
        delay_gain     = DELAY_GAIN_RST;
        feedback_gain  = FEEDBACK_GAIN_RST;
        dry_gain       = DRY_GAIN_RST;
        wet_gain       = WET_GAIN_RST;
        feedback_on    = 1'b0;
        failures       = 0;
        frames_checked = 0;
    endfunction

    // Mirror a register write; spare indexes are ignored by the block
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DELAY_FRAMES:    delay_frames  = data[DELAY_W-1:0];
            CFG_DELAY_GAIN:      delay_gain    = data[GAIN_W-1:0];
            CFG_FEEDBACK_GAIN:   feedback_gain = data[GAIN_W-1:0];
            CFG_DRY_GAIN:        dry_gain      = data[GAIN_W-1:0];
            CFG_WET_GAIN:        wet_gain      = data[GAIN_W-1:0];
            CFG_FEEDBACK_ENABLE: feedback_on   = data[0];
            default: ;
        endcase
    endfunction

    function logic signed [SAMPLE_W-1:0] clip_q15(longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // Write the frame, read back the interpolated delayed frame and form the mix
    function void note_frame(logic signed [SAMPLE_W-1:0] left,
                             logic signed [SAMPLE_W-1:0] right);
        logic signed [SAMPLE_W-1:0] sample_in [2];
        logic [DELAY_W-1:0]         d;
        int unsigned                whole;
        int unsigned                frac_part;
        int unsigned                rd_a;
        int unsigned                rd_b;
        longint                     x;
        longint                     s1;
        longint                     s2;
        longint                     interp;
        longint                     delayed;
        longint                     mix;
        stereo_frame_t              want;
        sample_in[0] = left;
        sample_in[1] = right;
        d         = (delay_frames > DELAY_LIMIT) ? DELAY_LIMIT[DELAY_W-1:0] : delay_frames;
        whole     = d >> FRAC_BITS;
        frac_part = d[FRAC_BITS-1:0];
        rd_a      = (BUFFER_FRAMES + write_pos - whole) % BUFFER_FRAMES;
        rd_b      = (BUFFER_FRAMES + rd_a - 1) % BUFFER_FRAMES;
        want.left  = '0;
        want.right = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            x = sample_in[c];
            // the input lands first, so a sub-frame delay sees it unfed-back
            frames[write_pos][c] = sample_in[c];
            s1 = frames[rd_a][c];
            s2 = frames[rd_b][c];
            interp  = s1 + ((longint'(frac_part) * (s2 - s1)) >>> FRAC_BITS);
            delayed = (longint'(delay_gain) * interp) >>> 14;
            if (feedback_on) begin
                frames[write_pos][c] =
                    clip_q15(x + ((delayed * longint'(feedback_gain)) >>> 14));
            end
            mix = x * longint'(dry_gain) + delayed * longint'(wet_gain);
            if (c == 0) begin
                want.left = clip_q15(mix >>> 14);
            end else begin
                want.right = clip_q15(mix >>> 14);
            end
        end
        write_pos = (write_pos + 1) % BUFFER_FRAMES;
        pending_frames.push_back(want);
    endfunction

    function void note_failure(string msg);
        failures++;
        if (failures <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Compare an output transaction with the oldest predicted frame
    function void check_frame(logic signed [SAMPLE_W-1:0] left,
                              logic signed [SAMPLE_W-1:0] right);
        stereo_frame_t want;
        if (pending_frames.size() == 0) begin
            note_failure($sformatf("unexpected output frame: left %0d right %0d",
                                   left, right));
            return;
        end
        want = pending_frames.pop_front();
        if (want.left !== left || want.right !== right) begin
            note_failure($sformatf(
                "frame %0d: expected left %0d right %0d, got left %0d right %0d",
                frames_checked, want.left, want.right, left, right));
        end
        frames_checked++;
    endfunction

    function int pending();
        return pending_frames.size();
    endfunction
endclass

module fractional_feedback_delay_line_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 228;
    localparam int CYCLE_LIMIT      = 500000;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata   = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_left_in   = '0;
    logic signed [SAMPLE_W-1:0] s_right_in  = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;

    delay_line_scoreboard sb;
    bit                   reset_done = 1'b0;
    bit                   no_idle    = 1'b0;
    int                   cycle_count = 0;

    fractional_feedback_delay_line dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int idle_draw();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return 16'($urandom_range(0, 255)) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return 16'sd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly short delays so that delayed frames carry recent data
    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 5))
            0: return 20'($urandom_range(0, 255));
            1, 2: return 20'($urandom_range(256, 40 * 256));
            3: return 20'($urandom_range(0, 1048575));
            4: return 20'($urandom_range(DELAY_LIMIT - 255, 1048575));
            default: return 20'($urandom_range(0, 300 * 256));
        endcase
    endfunction

    // One register write per clock
    task automatic program_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
    endtask

    // Load every register; unused data bits carry random noise
    task automatic program_all(logic [DELAY_W-1:0] delay, logic signed [GAIN_W-1:0] dg,
                               logic signed [GAIN_W-1:0] fg, logic signed [GAIN_W-1:0] dry,
                               logic signed [GAIN_W-1:0] wet, bit fb_en, bit spare);
        program_reg(CFG_DELAY_FRAMES, delay);
        program_reg(CFG_DELAY_GAIN, {4'($urandom), dg});
        program_reg(CFG_FEEDBACK_GAIN, {4'($urandom), fg});
        program_reg(CFG_DRY_GAIN, {4'($urandom), dry});
        program_reg(CFG_WET_GAIN, {4'($urandom), wet});
        program_reg(CFG_FEEDBACK_ENABLE, {19'($urandom), fb_en});
        if (spare) begin
            program_reg(CFG_SPARE_LO, 20'($urandom));
            program_reg(CFG_SPARE_HI, 20'($urandom));
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offer one frame after a random gap and hold it until the transaction
    task automatic send_frame(logic signed [SAMPLE_W-1:0] left,
                              logic signed [SAMPLE_W-1:0] right);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_left_in  <= left;
        s_right_in <= right;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        sb.note_frame(left, right);
    endtask

    // Drop valid and wait until every predicted frame has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) begin
            @(posedge aclk);
        end
    endtask

    // Output side: random back-pressure, check each transaction
    initial begin
        int stall;
        wait (reset_done);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!(m_valid && m_ready));
            sb.check_frame(m_left_out, m_right_out);
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn    <= 1'b1;
        reset_done = 1'b1;

        // Defaults: delay at its ceiling reads untouched (zero) frames
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh0000, 16'shFFFF);
        send_frame(16'shFFFF, 16'sh0000);
        drain();

        // Zero delay: the read returns the sample just written
        program_all(20'd0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh0001, 16'shFFFF);
        send_frame(16'sh5555, 16'shAAAA);
        drain();

        // Half-frame delay with opposite-sign extremes
        program_all(20'h00080, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(16'shAAAA, 16'sh5555);
        send_frame(16'sh0000, 16'sh0000);
        drain();

        // Over-long delay gets clamped; spare indexes must change nothing
        program_all(20'hFFFFF, 16'sd16384, 16'sd0, 16'sd16384, 16'sd16384, 1'b0, 1'b1);
        send_frame(16'sh1234, 16'shEDCB);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh0F0F, 16'shF0F0);
        drain();

        // Fractional delay of almost three frames with strong feedback
        program_all(20'h002FF, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 1'b1, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh0000, 16'sh0000);
        send_frame(16'sh4000, 16'shC000);
        send_frame(16'sh0000, 16'sh0000);
        drain();

        // Random settings per phase, some phases without idle cycles
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_idle = 1'b0;
            program_all(pick_delay(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                        p[0], $urandom_range(0, 3) == 0);
            no_idle = (p % 3 == 2);
            for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
                send_frame(pick_sample(), pick_sample());
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
